### rtl/core/atatf_pkg.sv
// Shared types and constants for the ATA task-file command builder.
// Used by every module under rtl/core; no dependencies of its own.
`default_nettype none
package atatf_pkg;

	localparam int AddrW          = 48;
	localparam int CountW         = 32;
	localparam int ChunkW         = 16;
	localparam int SectorBitsDef  = 48;
	localparam int QueueDepth     = 4;
	localparam int DivW           = 32;
	localparam int DivBits        = 8;
	localparam int DivRounds      = DivW / DivBits;

	localparam logic [1:0] MODE_CHS   = 2'd0;
	localparam logic [1:0] MODE_LBA28 = 2'd1;
	localparam logic [1:0] MODE_LBA48 = 2'd2;
	localparam logic [1:0] MODE_ALT48 = 2'd3;

	localparam logic [2:0] CFG_MODE     = 3'd0;
	localparam logic [2:0] CFG_WPROT    = 3'd1;
	localparam logic [2:0] CFG_TOTAL    = 3'd2;
	localparam logic [2:0] CFG_LIM_CYL  = 3'd3;
	localparam logic [2:0] CFG_LIM_HEAD = 3'd4;
	localparam logic [2:0] CFG_LIM_SPT  = 3'd5;
	localparam logic [2:0] CFG_GEO_HEAD = 3'd6;
	localparam logic [2:0] CFG_GEO_SPT  = 3'd7;

	localparam logic [1:0] KIND_FAIL  = 2'd0;
	localparam logic [1:0] KIND_CHS   = 2'd1;
	localparam logic [1:0] KIND_LBA28 = 2'd2;
	localparam logic [1:0] KIND_LBA48 = 2'd3;

	localparam logic [2:0] TF_NONE    = 3'd0;
	localparam logic [2:0] TF_COUNT   = 3'd2;
	localparam logic [2:0] TF_SECTOR  = 3'd3;
	localparam logic [2:0] TF_CYL_LO  = 3'd4;
	localparam logic [2:0] TF_CYL_HI  = 3'd5;
	localparam logic [2:0] TF_DEVICE  = 3'd6;
	localparam logic [2:0] TF_COMMAND = 3'd7;

	localparam logic [7:0] CMD_READ      = 8'h20;
	localparam logic [7:0] CMD_WRITE     = 8'h30;
	localparam logic [7:0] CMD_READ_EXT  = 8'h24;
	localparam logic [7:0] CMD_WRITE_EXT = 8'h34;
	localparam logic [7:0] DEV_LBA       = 8'hE0;
	localparam logic [7:0] DEV_CHS       = 8'hA0;
	localparam logic [ChunkW-1:0] MaxChunkWide = 16'hFFFF;
	localparam logic [ChunkW-1:0] MaxChunk     = 16'h00FF;

	typedef struct packed {
		logic [1:0]        address_mode;
		logic              write_protect;
		logic [AddrW-1:0]  total_sectors;
		logic [15:0]       limit_cylinders;
		logic [7:0]        limit_heads;
		logic [7:0]        limit_sectors_per_track;
		logic [7:0]        geometry_heads;
		logic [7:0]        geometry_sectors_per_track;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic              wr;
		logic [ChunkW-1:0] xfer;
		logic [AddrW-1:0]  lba;
	} desc_t;

	typedef struct packed {
		logic [2:0]        reg_index;
		logic [7:0]        reg_value;
		logic [ChunkW-1:0] chunk_sectors;
		logic              failed;
		logic              last;
	} row_t;

endpackage
`default_nettype wire

### rtl/core/atatf_front.sv
// Front end: accepts requests, computes the capacity and runs the refusal checks.
// Produces one descriptor per request; depends on atatf_pkg.
`default_nettype none
module atatf_front
	import atatf_pkg::*;
#(
	parameter int SECTOR_ADDR_BITS = SectorBitsDef
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [AddrW-1:0]  in_lba,
	input  wire logic [CountW-1:0] in_count,
	input  wire logic              in_wr,
	output logic                   push_valid,
	input  wire logic              push_ready,
	output desc_t                  push_desc
);

	localparam int LbaW = (SECTOR_ADDR_BITS < AddrW) ? SECTOR_ADDR_BITS : AddrW;
	localparam int ChW  = 24;
	localparam int CapW = 32;

	logic advance;
	logic logical;
	logic wide;
	logic v_s1, v_s2, v_s3, v_s4;

	logic [LbaW-1:0]   lba_s1, lba_s2, lba_s3, lba_s4;
	logic [CountW-1:0] count_s1, count_s2, count_s3;
	logic              wr_s1, wr_s2, wr_s3, wr_s4;
	logic [ChW-1:0]    ch_s1;
	logic [AddrW-1:0]  cap_s2;
	logic              pre_s2;
	logic [AddrW-1:0]  diff_s3;
	logic              over_s3;
	logic              fail_s4;
	logic [ChunkW-1:0] xfer_s4;
	logic [1:0]        kind_s4;

	assign logical  = (cfg.address_mode != MODE_CHS);
	assign wide     = (cfg.address_mode == MODE_LBA48) || (cfg.address_mode == MODE_ALT48);
	assign advance  = !v_s4 || push_ready;
	assign in_ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			lba_s1   <= in_lba[LbaW-1:0];
			count_s1 <= in_count;
			wr_s1    <= in_wr;
			ch_s1    <= ChW'(cfg.limit_cylinders) * ChW'(cfg.limit_heads);

			lba_s2   <= lba_s1;
			count_s2 <= count_s1;
			wr_s2    <= wr_s1;
			cap_s2   <= logical ? cfg.total_sectors
			                    : AddrW'(CapW'(ch_s1) * CapW'(cfg.limit_sectors_per_track));
			pre_s2   <= (wr_s1 && cfg.write_protect) || (count_s1 == '0) ||
			            (!logical && ((cfg.geometry_heads == '0) ||
			                          (cfg.geometry_sectors_per_track == '0)));

			lba_s3   <= lba_s2;
			count_s3 <= count_s2;
			wr_s3    <= wr_s2;
			diff_s3  <= cap_s2 - AddrW'(count_s2);
			over_s3  <= pre_s2 || (cap_s2 == '0) || (AddrW'(count_s2) > cap_s2);

			lba_s4   <= lba_s3;
			wr_s4    <= wr_s3;
			fail_s4  <= over_s3 || (AddrW'(lba_s3) > diff_s3);
			if (wide) begin
				xfer_s4 <= (count_s3 > CountW'(MaxChunkWide)) ? MaxChunkWide
				                                               : count_s3[ChunkW-1:0];
			end else begin
				xfer_s4 <= (count_s3 > CountW'(MaxChunk)) ? MaxChunk
				                                          : count_s3[ChunkW-1:0];
			end
			kind_s4  <= wide ? KIND_LBA48 : (logical ? KIND_LBA28 : KIND_CHS);
		end
	end

	assign push_valid     = v_s4;
	assign push_desc.kind = fail_s4 ? KIND_FAIL : kind_s4;
	assign push_desc.wr   = wr_s4;
	assign push_desc.xfer = xfer_s4;
	assign push_desc.lba  = AddrW'(lba_s4);

endmodule
`default_nettype wire

### rtl/core/atatf_fifo.sv
// Short descriptor queue between the front end and the back end.
// Depends on atatf_pkg for the descriptor type and depth.
`default_nettype none
module atatf_fifo
	import atatf_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push_valid,
	output logic       push_ready,
	input  wire desc_t push_desc,
	output logic       pop_valid,
	input  wire logic  pop_ready,
	output desc_t      pop_desc
);

	localparam int PtrW = $clog2(QueueDepth);
	localparam int CntW = $clog2(QueueDepth + 1);

	desc_t           mem_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_push, do_pop;

	assign push_ready = (cnt_q != CntW'(QueueDepth));
	assign pop_valid  = (cnt_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_desc   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

endmodule
`default_nettype wire

### rtl/core/atatf_div.sv
// Iterative 32-by-8 unsigned divider, eight quotient bits per cycle.
// Used by the back end for the sector to cylinder-head-sector conversion.
`default_nettype none
module atatf_div
	import atatf_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [DivW-1:0] dividend,
	input  wire logic [7:0]      divisor,
	output logic                 done,
	output logic [DivW-1:0]      quotient,
	output logic [7:0]           remainder
);

	localparam int RndW = $clog2(DivRounds);

	logic [DivW-1:0]    quo_q;
	logic [7:0]         rem_q;
	logic [7:0]         div_q;
	logic [RndW-1:0]    rnd_q;
	logic               busy_q;
	logic               done_q;
	logic [7:0]         rem_next;
	logic [DivBits-1:0] qbits;

	always_comb begin
		logic [8:0] part;
		logic [7:0] r;
		r     = rem_q;
		qbits = '0;
		for (int i = 0; i < DivBits; i++) begin
			part = {r, quo_q[DivW-1-i]};
			if (part >= {1'b0, div_q}) begin
				part             = part - {1'b0, div_q};
				qbits[DivBits-1-i] = 1'b1;
			end
			r = part[7:0];
		end
		rem_next = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + RndW'(1);
				if (rnd_q == RndW'(DivRounds - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DivW-DivBits-1:0], qbits};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

### rtl/core/atatf_back.sv
// Back end: takes descriptors, converts CHS addresses and emits the register writes.
// Instantiates atatf_div; depends on atatf_pkg.
`default_nettype none
module atatf_back
	import atatf_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  pop_valid,
	output logic       pop_ready,
	input  wire desc_t pop_desc,
	output logic       out_valid,
	input  wire logic  out_ready,
	output row_t       out_row
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV1 = 2'd1;
	localparam logic [1:0] ST_DIV2 = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]      state_q;
	logic [3:0]      step_q;
	desc_t           desc_q;
	logic [7:0]      sec_q;
	logic [3:0]      head_q;
	logic [15:0]     cyl_q;
	row_t            out_q;
	logic            out_valid_q;
	row_t            row;
	logic            slot_free;
	logic            div_start;
	logic [DivW-1:0] div_dividend;
	logic [7:0]      div_divisor;
	logic            div_done;
	logic [DivW-1:0] div_quo;
	logic [7:0]      div_rem;
	logic [7:0]      cmd;

	atatf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign pop_ready    = (state_q == ST_IDLE);
	assign slot_free    = !out_valid_q || out_ready;
	assign div_start    = ((state_q == ST_IDLE) && pop_valid && (pop_desc.kind == KIND_CHS)) ||
	                      ((state_q == ST_DIV1) && div_done);
	assign div_dividend = (state_q == ST_DIV1) ? div_quo : pop_desc.lba[DivW-1:0];
	assign div_divisor  = (state_q == ST_DIV1) ? cfg.geometry_heads
	                                           : cfg.geometry_sectors_per_track;

	always_comb begin
		if (desc_q.kind == KIND_LBA48) begin
			cmd = desc_q.wr ? CMD_WRITE_EXT : CMD_READ_EXT;
		end else begin
			cmd = desc_q.wr ? CMD_WRITE : CMD_READ;
		end
	end

	always_comb begin
		row.reg_index     = TF_NONE;
		row.reg_value     = '0;
		row.chunk_sectors = desc_q.xfer;
		row.failed        = 1'b0;
		row.last          = 1'b0;
		unique case (desc_q.kind)
			KIND_FAIL: begin
				row.chunk_sectors = '0;
				row.failed        = 1'b1;
				row.last          = 1'b1;
			end
			KIND_LBA48: begin
				case (step_q)
					4'd0: begin row.reg_index = TF_COUNT;  row.reg_value = desc_q.xfer[15:8]; end
					4'd1: begin row.reg_index = TF_SECTOR; row.reg_value = desc_q.lba[31:24]; end
					4'd2: begin row.reg_index = TF_CYL_LO; row.reg_value = desc_q.lba[39:32]; end
					4'd3: begin row.reg_index = TF_CYL_HI; row.reg_value = desc_q.lba[47:40]; end
					4'd4: begin row.reg_index = TF_COUNT;  row.reg_value = desc_q.xfer[7:0]; end
					4'd5: begin row.reg_index = TF_SECTOR; row.reg_value = desc_q.lba[7:0]; end
					4'd6: begin row.reg_index = TF_CYL_LO; row.reg_value = desc_q.lba[15:8]; end
					4'd7: begin row.reg_index = TF_CYL_HI; row.reg_value = desc_q.lba[23:16]; end
					4'd8: begin row.reg_index = TF_DEVICE; row.reg_value = DEV_LBA; end
					default: begin
						row.reg_index = TF_COMMAND;
						row.reg_value = cmd;
						row.last      = 1'b1;
					end
				endcase
			end
			KIND_LBA28: begin
				case (step_q)
					4'd0: begin row.reg_index = TF_COUNT;  row.reg_value = desc_q.xfer[7:0]; end
					4'd1: begin row.reg_index = TF_SECTOR; row.reg_value = desc_q.lba[7:0]; end
					4'd2: begin row.reg_index = TF_CYL_LO; row.reg_value = desc_q.lba[15:8]; end
					4'd3: begin row.reg_index = TF_CYL_HI; row.reg_value = desc_q.lba[23:16]; end
					4'd4: begin
						row.reg_index = TF_DEVICE;
						row.reg_value = DEV_LBA | {4'd0, desc_q.lba[27:24]};
					end
					default: begin
						row.reg_index = TF_COMMAND;
						row.reg_value = cmd;
						row.last      = 1'b1;
					end
				endcase
			end
			default: begin
				case (step_q)
					4'd0: begin row.reg_index = TF_COUNT;  row.reg_value = desc_q.xfer[7:0]; end
					4'd1: begin row.reg_index = TF_SECTOR; row.reg_value = sec_q; end
					4'd2: begin row.reg_index = TF_CYL_LO; row.reg_value = cyl_q[7:0]; end
					4'd3: begin row.reg_index = TF_CYL_HI; row.reg_value = cyl_q[15:8]; end
					4'd4: begin
						row.reg_index = TF_DEVICE;
						row.reg_value = DEV_CHS | {4'd0, head_q};
					end
					default: begin
						row.reg_index = TF_COMMAND;
						row.reg_value = cmd;
						row.last      = 1'b1;
					end
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_EMIT) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (pop_valid) begin
						state_q <= (pop_desc.kind == KIND_CHS) ? ST_DIV1 : ST_EMIT;
					end
				end
				ST_DIV1: begin
					if (div_done) begin
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						step_q <= step_q + 4'd1;
						if (row.last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && pop_valid) begin
			desc_q <= pop_desc;
		end
		if ((state_q == ST_DIV1) && div_done) begin
			sec_q <= div_rem + 8'd1;
		end
		if ((state_q == ST_DIV2) && div_done) begin
			head_q <= div_rem[3:0];
			cyl_q  <= div_quo[15:0];
		end
		if ((state_q == ST_EMIT) && slot_free) begin
			out_q <= row;
		end
	end

	assign out_valid = out_valid_q;
	assign out_row   = out_q;

endmodule
`default_nettype wire

### rtl/core/ata_taskfile_command_builder.sv
// ATA task-file command builder top level: configuration registers, front end,
// descriptor queue and back end. Depends on atatf_pkg and all atatf_* modules.
// A request passes the front-end stages, the queue and the back end's IDLE and EMIT
// states, plus DIV1 and DIV2 in CHS mode. A new descriptor is taken only after the
// previous one's last row: ten rows in 48-bit mode, six in 28-bit or CHS, one if refused.
// Reset clears the queue and control state; write_protect resets to 1, others to 0.
`default_nettype none
module ata_taskfile_command_builder
	import atatf_pkg::*;
#(
	parameter int SECTOR_ADDR_BITS = SectorBitsDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [79:0] s_axis_tdata,  // start_sector[47:0], sectors_left[79:48]
	input  wire logic        s_axis_tuser,  // is_write
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // reg_index[2:0], reg_value[10:3], chunk_sectors[26:11]
	output logic             m_axis_tuser,  // failed
	output logic             m_axis_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);

	cfg_t  cfg_q;
	logic  push_valid, push_ready;
	desc_t push_desc;
	logic  pop_valid, pop_ready;
	desc_t pop_desc;
	row_t  out_row;
	logic  cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.address_mode               <= MODE_CHS;
			cfg_q.write_protect              <= 1'b1;
			cfg_q.total_sectors              <= '0;
			cfg_q.limit_cylinders            <= '0;
			cfg_q.limit_heads                <= '0;
			cfg_q.limit_sectors_per_track    <= '0;
			cfg_q.geometry_heads             <= '0;
			cfg_q.geometry_sectors_per_track <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[5:3])
				CFG_MODE:     cfg_q.address_mode               <= pwdata[1:0];
				CFG_WPROT:    cfg_q.write_protect              <= pwdata[0];
				CFG_TOTAL:    cfg_q.total_sectors              <= pwdata[AddrW-1:0];
				CFG_LIM_CYL:  cfg_q.limit_cylinders            <= pwdata[15:0];
				CFG_LIM_HEAD: cfg_q.limit_heads                <= pwdata[7:0];
				CFG_LIM_SPT:  cfg_q.limit_sectors_per_track    <= pwdata[7:0];
				CFG_GEO_HEAD: cfg_q.geometry_heads             <= pwdata[7:0];
				default:      cfg_q.geometry_sectors_per_track <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[5:3])
			CFG_MODE:     prdata = 64'(cfg_q.address_mode);
			CFG_WPROT:    prdata = 64'(cfg_q.write_protect);
			CFG_TOTAL:    prdata = 64'(cfg_q.total_sectors);
			CFG_LIM_CYL:  prdata = 64'(cfg_q.limit_cylinders);
			CFG_LIM_HEAD: prdata = 64'(cfg_q.limit_heads);
			CFG_LIM_SPT:  prdata = 64'(cfg_q.limit_sectors_per_track);
			CFG_GEO_HEAD: prdata = 64'(cfg_q.geometry_heads);
			default:      prdata = 64'(cfg_q.geometry_sectors_per_track);
		endcase
	end

	atatf_front #(
		.SECTOR_ADDR_BITS (SECTOR_ADDR_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_lba     (s_axis_tdata[47:0]),
		.in_count   (s_axis_tdata[79:48]),
		.in_wr      (s_axis_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc)
	);

	atatf_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_desc   (pop_desc)
	);

	atatf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_desc  (pop_desc),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_row   (out_row)
	);

	assign m_axis_tdata = {5'd0, out_row.chunk_sectors, out_row.reg_value, out_row.reg_index};
	assign m_axis_tuser = out_row.failed;
	assign m_axis_tlast = out_row.last;

endmodule
`default_nettype wire
